@@ hw/rtl/sha256_compression_macros.svh @@
// Assertion macros for the SHA-256 compression block.
`ifndef SHA256_COMPRESSION_MACROS_SVH
`define SHA256_COMPRESSION_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on each rising edge, suspended while reset is asserted.
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check a property on each rising edge, reset included.
`define SHA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SHA_ASSERT(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ hw/rtl/sha256c_pkg.sv @@
// Types, constants and SHA-256 round functions shared by the compression block.
package sha256c_pkg;

	// Request kinds carried in tuser on the input side
	localparam logic REQ_CHAIN = 1'b0;
	localparam logic REQ_MSG   = 1'b1;

	localparam int CHAIN_WORDS  = 8;
	localparam int MSG_WORDS    = 16;
	localparam int ROUNDS       = 64;
	localparam int WORD_W       = 32;
	localparam int IDX_W        = 4;
	localparam int CHAIN_IDX_W  = 3;
	localparam int ROUND_W      = 6;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 40;

	localparam logic [IDX_W-1:0]       LAST_MSG_IDX   = 4'd15;
	localparam logic [CHAIN_IDX_W-1:0] LAST_CHAIN_IDX = 3'd7;
	localparam logic [ROUND_W-1:0]     LAST_ROUND     = 6'd63;

	// Command queue between front and core
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		CMD_CHAIN,
		CMD_MSG,
		CMD_START
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [WORD_W-1:0]  word;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FEED,
		CORE_EMIT
	} core_state_t;

	typedef struct packed {
		logic busy;
		logic pop;
		logic last_round;
		logic feeding;
		logic emitting;
	} core_status_t;

	function automatic logic [WORD_W-1:0] byte_rev(input logic [WORD_W-1:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Round constants K0..K63
	function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
		logic [WORD_W-1:0] k;
		case (t)
			6'd0:  k = 32'h428A2F98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hB5C0FBCF;
			6'd3:  k = 32'hE9B5DBA5;
			6'd4:  k = 32'h3956C25B;
			6'd5:  k = 32'h59F111F1;
			6'd6:  k = 32'h923F82A4;
			6'd7:  k = 32'hAB1C5ED5;
			6'd8:  k = 32'hD807AA98;
			6'd9:  k = 32'h12835B01;
			6'd10: k = 32'h243185BE;
			6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74;
			6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7;
			6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1;
			6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6;
			6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F;
			6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC;
			6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152;
			6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8;
			6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3;
			6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85;
			6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC;
			6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354;
			6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E;
			6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1;
			6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70;
			6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819;
			6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585;
			6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116;
			6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C;
			6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3;
			6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F;
			6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE;
			6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814;
			6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA;
			6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7;
			6'd63: k = 32'hC67178F2;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

@@ hw/rtl/sha256c_front.sv @@
// Input front end: accepts words, classifies them and byte-swaps message words.
module sha256c_front (
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sha256c_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  sha256c_pkg::queue_status_t       q_status,
	output logic                             q_push,
	output sha256c_pkg::cmd_t                q_cmd
);
	import sha256c_pkg::*;

	logic [IDX_W-1:0]  in_idx;
	logic [WORD_W-1:0] in_word;
	logic              chain_ok;

	assign in_idx   = s_axis_tdata[IDX_W-1:0];
	assign in_word  = s_axis_tdata[IDX_W +: WORD_W];
	assign chain_ok = (in_idx[IDX_W-1:CHAIN_IDX_W] == '0);

	// Take a word whenever the queue has room
	assign s_axis_tready = !q_status.full;

	// Classify the word; chaining writes beyond word 7 are accepted and dropped
	always_comb begin
		q_cmd.idx  = in_idx;
		q_cmd.word = in_word;
		q_cmd.kind = CMD_CHAIN;
		q_push     = 1'b0;
		if (s_axis_tuser == REQ_MSG) begin
			q_cmd.word = byte_rev(in_word);
			q_cmd.kind = (in_idx == LAST_MSG_IDX) ? CMD_START : CMD_MSG;
			q_push     = s_axis_tvalid && s_axis_tready;
		end else begin
			q_push     = s_axis_tvalid && s_axis_tready && chain_ok;
		end
	end

endmodule

@@ hw/rtl/sha256c_queue.sv @@
// Short command queue between the front end and the compression core.
module sha256c_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  sha256c_pkg::cmd_t          push_cmd,
	input  logic                       pop,
	output sha256c_pkg::cmd_t          head_cmd,
	output sha256c_pkg::queue_status_t status
);
	import sha256c_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_cmd     = mem_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/sha256c_core.sv @@
// Compression core: word stores, round unit, feed-forward and result output.
module sha256c_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sha256c_pkg::cmd_t                      q_cmd,
	input  sha256c_pkg::queue_status_t             q_status,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [sha256c_pkg::CHAIN_IDX_W-1:0]    out_idx,
	output logic [sha256c_pkg::WORD_W-1:0]         out_word,
	output logic                                   out_last,
	output sha256c_pkg::core_status_t              status
);
	import sha256c_pkg::*;

	core_state_t            state_q;
	core_state_t            state_d;
	logic [WORD_W-1:0]      chain_q [CHAIN_WORDS];
	logic [WORD_W-1:0]      msg_q   [MSG_WORDS];
	logic [WORD_W-1:0]      w_q     [MSG_WORDS];
	logic [WORD_W-1:0]      v_q     [CHAIN_WORDS];
	logic [ROUND_W-1:0]     round_q;
	logic [CHAIN_IDX_W-1:0] emit_q;
	logic                   out_valid_q;
	logic [CHAIN_IDX_W-1:0] out_idx_q;
	logic [WORD_W-1:0]      out_word_q;
	logic                   out_last_q;

	logic              out_free;
	logic              load_out;
	logic              start;
	logic              do_round;
	logic              do_feed;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] ch;
	logic [WORD_W-1:0] maj;
	logic [WORD_W-1:0] w_next;

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CORE_IDLE: begin
				if (!q_status.empty && q_cmd.kind == CMD_START) begin
					state_d = CORE_ROUND;
				end
			end
			CORE_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_d = CORE_FEED;
				end
			end
			CORE_FEED: begin
				state_d = CORE_EMIT;
			end
			CORE_EMIT: begin
				if (out_free && emit_q == LAST_CHAIN_IDX) begin
					state_d = CORE_IDLE;
				end
			end
			default: begin
				state_d = CORE_IDLE;
			end
		endcase
	end

	// Control outputs per state
	always_comb begin
		q_pop    = 1'b0;
		start    = 1'b0;
		do_round = 1'b0;
		do_feed  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			CORE_IDLE: begin
				q_pop = !q_status.empty;
				start = !q_status.empty && q_cmd.kind == CMD_START;
			end
			CORE_ROUND: begin
				do_round = 1'b1;
			end
			CORE_FEED: begin
				do_feed = 1'b1;
			end
			CORE_EMIT: begin
				load_out = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Round function on a..h and the message schedule window
	always_comb begin
		ch     = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
		maj    = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
		t1     = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(round_q) + w_q[0];
		t2     = big_sigma0(v_q[0]) + maj;
		w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CORE_IDLE;
			round_q     <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				round_q <= '0;
			end else if (do_round) begin
				round_q <= round_q + 1'b1;
			end
			if (do_feed) begin
				emit_q <= '0;
			end else if (load_out) begin
				emit_q <= emit_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Chaining words: software writes and feed-forward addition
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= '0;
			end
		end else if (do_feed) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end else if (q_pop && q_cmd.kind == CMD_CHAIN) begin
			chain_q[q_cmd.idx[CHAIN_IDX_W-1:0]] <= q_cmd.word;
		end
	end

	// Message store, schedule window and working variables
	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.kind == CMD_MSG || q_cmd.kind == CMD_START)) begin
			msg_q[q_cmd.idx] <= q_cmd.word;
		end
		if (start) begin
			for (int i = 0; i < MSG_WORDS - 1; i++) begin
				w_q[i] <= msg_q[i];
			end
			w_q[MSG_WORDS-1] <= q_cmd.word;
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (do_round) begin
			for (int i = 0; i < MSG_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[MSG_WORDS-1] <= w_next;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= emit_q;
			out_word_q <= chain_q[emit_q];
			out_last_q <= (emit_q == LAST_CHAIN_IDX);
		end
	end

	assign out_valid = out_valid_q;
	assign out_idx   = out_idx_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;

	assign status.busy       = (state_q != CORE_IDLE);
	assign status.pop        = q_pop;
	assign status.last_round = do_round && (round_q == LAST_ROUND);
	assign status.feeding    = do_feed;
	assign status.emitting   = load_out;

endmodule

@@ hw/rtl/sha256_compression.sv @@
// Top level of the SHA-256/224 compression block.
//
//  channel  | direction | tdata (low bit up)                 | tuser    | tlast
//  s_axis   | in        | word_index[3:0], data_word[35:4]   | req_type | -
//  m_axis   | out       | out_index[2:0], out_word[34:3]     | -        | out_last
//
// The front end passes each input word on to the two-entry command queue, and the
// core takes it from the head of the queue while idle. Message word 15 starts the
// core, which then runs 64 rounds through the single round unit, one feed-forward
// step and eight result words before it takes the next word from the queue.
// Reset is asynchronous and active low; chaining words come up as zero.
// A stalled m_axis holds the core in its result phase; the queue keeps taking
// words until it is full.
`include "sha256_compression_macros.svh"

module sha256_compression (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // word_index[3:0], data_word[35:4], zero pad
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // out_index[2:0], out_word[34:3], zero pad
	output logic        m_axis_tlast
);
	import sha256c_pkg::*;

	cmd_t                   push_cmd;
	cmd_t                   head_cmd;
	logic                   q_push;
	logic                   q_pop;
	queue_status_t          q_status;
	core_status_t           core_status;
	logic [CHAIN_IDX_W-1:0] out_idx;
	logic [WORD_W-1:0]      out_word;

	sha256c_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	sha256c_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.status   (q_status)
	);

	sha256c_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (head_cmd),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_idx   (out_idx),
		.out_word  (out_word),
		.out_last  (m_axis_tlast),
		.status    (core_status)
	);

	// Pack the result word
	assign m_axis_tdata = {{(OUT_TDATA_W - CHAIN_IDX_W - WORD_W){1'b0}}, out_word, out_idx};

	// Commands leave the queue only while the core is idle
	`SHA_ASSERT(a_pop_when_idle, clk, arst_n, core_status.pop |-> !core_status.busy, "queue popped while core busy")

	// The last round is followed by the feed-forward
	`SHA_ASSERT(a_feed_after_rounds, clk, arst_n, core_status.last_round |=> core_status.feeding, "feed-forward missed after last round")

	// A new result appears only from the result phase
	`SHA_ASSERT(a_result_source, clk, arst_n, $rose(m_axis_tvalid) |-> $past(core_status.emitting), "result raised outside result phase")

	// The queue is never both full and empty
	`SHA_ASSERT_ALWAYS(a_queue_level, clk, !(q_status.full && q_status.empty), "queue level inconsistent")

endmodule
